>>> rtl/nsc_pkg.sv
// nsc_pkg: shared constants, result type and a helper for the sentence checker
// used by nsc_core and nmea_sentence_checker; no dependencies
package nsc_pkg;

  // default header length in characters and its reset value ("$GTIMU")
  localparam int unsigned HEADER_LEN   = 6;
  localparam logic [63:0] HEADER_RESET = 64'h0000_2447_5449_4D55;

  // special characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // byte class codes
  localparam logic [1:0] CLASS_DATA     = 2'd0;
  localparam logic [1:0] CLASS_SEP      = 2'd1;
  localparam logic [1:0] CLASS_CHECKSUM = 2'd2;
  localparam logic [1:0] CLASS_TRAILER  = 2'd3;

  // one result item
  typedef struct packed {
    logic [7:0] echo_byte;
    logic [3:0] field_index;
    logic [1:0] byte_class;
    logic       frame_done;
    logic       header_ok;
    logic       checksum_ok;
    logic       frame_valid;
  } result_t;

  // uppercase hex character of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = CHAR_ZERO + {4'b0000, v};
    end else begin
      r = CHAR_UPPER_A + {4'b0000, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

>>> rtl/nsc_core.sv
// nsc_core: per-frame sentence state and the combinational step that classifies
// a character and updates header, xor and checksum tracking; uses nsc_pkg
module nsc_core #(
  parameter int unsigned HeaderLen = nsc_pkg::HEADER_LEN
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             data_i,
  input  logic                   last_i,
  input  logic [8*HeaderLen-1:0] header_i,
  output nsc_pkg::result_t       result_o
);

  localparam int unsigned PosW = $clog2(HeaderLen + 1);

  // phase codes
  localparam logic [1:0] PhBefore = 2'd0;
  localparam logic [1:0] PhInside = 2'd1;
  localparam logic [1:0] PhAfter  = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      xor_q, xor_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            match_q, match_d;
  logic [3:0]      comma_q, comma_d;
  logic [7:0]      ch0_q, ch0_d, ch1_q, ch1_d;
  logic [2:0]      ast_cnt_q, ast_cnt_d;
  logic [7:0]      dl0_q, dl1_q;
  logic [1:0]      fill_q, fill_d;
  logic [1:0]      tail_q, tail_d;
  logic [1:0]      cls;
  logic [7:0]      want;
  logic [7:0]      ck;
  logic            hok, cok;

  // header byte expected at the current header position
  always_comb begin
    want = '0;
    for (int unsigned i = 0; i < HeaderLen; i++) begin
      if (pos_q == PosW'(i)) begin
        want = header_i[8*(HeaderLen-1-i) +: 8];
      end
    end
  end

  // class of the incoming character
  always_comb begin
    tail_d = tail_q;
    cls    = nsc_pkg::CLASS_TRAILER;
    if (tail_q == 2'd0) begin
      if (data_i == nsc_pkg::CHAR_STAR) begin
        cls    = nsc_pkg::CLASS_CHECKSUM;
        tail_d = 2'd1;
      end else if (data_i == nsc_pkg::CHAR_COMMA) begin
        cls = nsc_pkg::CLASS_SEP;
      end else begin
        cls = nsc_pkg::CLASS_DATA;
      end
    end else if (tail_q < 2'd3) begin
      cls    = nsc_pkg::CLASS_CHECKSUM;
      tail_d = tail_q + 2'd1;
    end
  end

  // comma counting, saturating
  assign comma_d = (data_i == nsc_pkg::CHAR_COMMA && comma_q != 4'hF) ? comma_q + 4'd1
                                                                       : comma_q;

  // check of the character two places back
  always_comb begin
    ck        = dl0_q;
    phase_d   = phase_q;
    xor_d     = xor_q;
    pos_d     = pos_q;
    match_d   = match_q;
    ch0_d     = ch0_q;
    ch1_d     = ch1_q;
    ast_cnt_d = ast_cnt_q;
    if (fill_q == 2'd2) begin
      if (pos_q < PosW'(HeaderLen)) begin
        if (ck != want) begin
          match_d = 1'b0;
        end
        pos_d = pos_q + 1'b1;
      end
      if (phase_q == PhAfter) begin
        if (ast_cnt_q == 3'd0) begin
          ch0_d = ck;
        end
        if (ast_cnt_q == 3'd1) begin
          ch1_d = ck;
        end
        if (ast_cnt_q != 3'd7) begin
          ast_cnt_d = ast_cnt_q + 3'd1;
        end
      end
      if (ck == nsc_pkg::CHAR_STAR) begin
        phase_d = PhAfter;
      end
      if (phase_d == PhInside) begin
        xor_d = xor_q ^ ck;
      end
      if (ck == nsc_pkg::CHAR_DOLLAR) begin
        phase_d = PhInside;
      end
    end
  end

  assign fill_d = (fill_q == 2'd2) ? 2'd2 : fill_q + 2'd1;

  // verdicts on the frame's last character
  assign hok = match_d && (pos_d >= PosW'(HeaderLen));
  assign cok = (ast_cnt_d == 3'd2) &&
               (ch0_d == nsc_pkg::hex_digit(xor_d[7:4])) &&
               (ch1_d == nsc_pkg::hex_digit(xor_d[3:0]));

  always_comb begin
    result_o.echo_byte   = data_i;
    result_o.field_index = comma_q;
    result_o.byte_class  = cls;
    result_o.frame_done  = last_i;
    result_o.header_ok   = last_i & hok;
    result_o.checksum_ok = last_i & cok;
    result_o.frame_valid = last_i & hok & cok;
  end

  // state update, cleared after each frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhBefore;
      xor_q     <= '0;
      pos_q     <= '0;
      match_q   <= 1'b1;
      comma_q   <= '0;
      ch0_q     <= '0;
      ch1_q     <= '0;
      ast_cnt_q <= '0;
      dl0_q     <= '0;
      dl1_q     <= '0;
      fill_q    <= '0;
      tail_q    <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q   <= PhBefore;
        xor_q     <= '0;
        pos_q     <= '0;
        match_q   <= 1'b1;
        comma_q   <= '0;
        ch0_q     <= '0;
        ch1_q     <= '0;
        ast_cnt_q <= '0;
        dl0_q     <= '0;
        dl1_q     <= '0;
        fill_q    <= '0;
        tail_q    <= '0;
      end else begin
        phase_q   <= phase_d;
        xor_q     <= xor_d;
        pos_q     <= pos_d;
        match_q   <= match_d;
        comma_q   <= comma_d;
        ch0_q     <= ch0_d;
        ch1_q     <= ch1_d;
        ast_cnt_q <= ast_cnt_d;
        dl0_q     <= dl1_q;
        dl1_q     <= data_i;
        fill_q    <= fill_d;
        tail_q    <= tail_d;
      end
    end
  end

endmodule

>>> rtl/nmea_sentence_checker.sv
// nmea_sentence_checker: byte-serial sentence checker, stream in and out
// a result passes through the input register and the output register before it is offered
// throughput: one character per cycle unless stalled; input register, one step, output register
// back pressure on the output stalls the input register, no item is dropped
// reset: async active low, clears the pipeline and frame state, header to default
// depends on nsc_pkg and nsc_core
module nmea_sentence_checker #(
  parameter int unsigned HeaderLen   = nsc_pkg::HEADER_LEN,
  parameter logic [63:0] HeaderReset = nsc_pkg::HEADER_RESET
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tlast,   // last_byte
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] echo_byte, [11:8] field_index, [12] header_ok, [13] checksum_ok,
  // [14] frame_valid, [15] zero
  output logic [15:0]            m_axis_tdata,
  output logic [1:0]             m_axis_tuser,   // [1:0] byte_class
  output logic                   m_axis_tlast,   // frame_done
  // header register write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [8*HeaderLen-1:0] cfg_data_i
);

  logic                   in_valid_q;
  logic [7:0]             in_data_q;
  logic                   in_last_q;
  logic                   out_valid_q;
  nsc_pkg::result_t       out_q;
  nsc_pkg::result_t       result;
  logic [8*HeaderLen-1:0] header_q;
  logic                   adv;
  logic                   step;

  // pipeline control
  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;
  assign cfg_ready_o   = 1'b1;

  // header register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset[8*HeaderLen-1:0];
    end else if (cfg_valid_i) begin
      header_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  nsc_core #(
    .HeaderLen(HeaderLen)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .data_i  (in_data_q),
    .last_i  (in_last_q),
    .header_i(header_q),
    .result_o(result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  // result transfer
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.frame_valid, out_q.checksum_ok, out_q.header_ok,
                          out_q.field_index, out_q.echo_byte};
  assign m_axis_tuser  = out_q.byte_class;
  assign m_axis_tlast  = out_q.frame_done;

endmodule

>>> sim/nmea_sentence_checker_tb.sv
// nmea_sentence_checker_tb: self-checking bench for the byte-serial sentence checker
// drives characters on the input stream, predicts each result locally (or uses a directed
// expectation) and compares it field by field; depends on nsc_pkg and nmea_sentence_checker
module nmea_sentence_checker_tb;

  localparam int unsigned HLEN = nsc_pkg::HEADER_LEN;

  typedef enum logic [1:0] {PH_BEFORE, PH_INSIDE, PH_AFTER} scan_phase_e;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [8*HLEN-1:0] cfg_data_i    = '0;

  nmea_sentence_checker uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard limit on run time
  initial begin
    #(12 * 400000);
    $display("** nmea_sentence_checker: FAILED **");
    $finish;
  end

  // predictor copy of the header register and frame state
  logic [8*HLEN-1:0] hdr_word;
  scan_phase_e       scan_ph;
  logic [7:0]        xsum;
  int unsigned       hdr_pos;
  bit                hdr_match;
  int unsigned       n_commas;
  logic [7:0]        tail_chars [4];
  int unsigned       tail_cnt;
  logic [7:0]        delay_chars [2];
  int unsigned       delay_fill;
  int unsigned       star_run;

  nsc_pkg::result_t  pending_results [$];
  int unsigned       mismatches = 0;
  bit                tx_burst = 1'b0;
  bit                rx_burst = 1'b0;

  // directed stimulus table
  logic [7:0]        dir_data  [$];
  logic              dir_last  [$];
  bit                dir_typed [$];
  nsc_pkg::result_t  dir_exp   [$];

  // current generated frame
  logic [7:0]        frame_q [$];

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h37 + {4'h0, n};
  endfunction

  // printable text, never a dollar, star or comma
  function automatic logic [7:0] rand_text();
    return 8'($urandom_range(8'h30, 8'h5A));
  endfunction

  task automatic clear_frame();
    scan_ph    = PH_BEFORE;
    xsum       = 8'h00;
    hdr_pos    = 0;
    hdr_match  = 1'b1;
    n_commas   = 0;
    for (int i = 0; i < 4; i++) tail_chars[i] = 8'h00;
    tail_cnt   = 0;
    delay_chars[0] = 8'h00;
    delay_chars[1] = 8'h00;
    delay_fill = 0;
    star_run   = 0;
  endtask

  // expected result for one character, advances the predictor state
  task automatic compute_result(input logic [7:0] c, input logic last,
                                output nsc_pkg::result_t r);
    logic [7:0] chk;
    logic [7:0] want;
    bit         hok;
    bit         cok;
    r = '0;
    r.echo_byte   = c;
    r.field_index = n_commas[3:0];

    // class: data and separators until the first star, then star plus two, then trailer
    if (star_run == 0) begin
      if (c == nsc_pkg::CHAR_STAR) begin
        r.byte_class = nsc_pkg::CLASS_CHECKSUM;
        star_run = 1;
      end else begin
        r.byte_class = (c == nsc_pkg::CHAR_COMMA) ? nsc_pkg::CLASS_SEP : nsc_pkg::CLASS_DATA;
      end
    end else if (star_run < 3) begin
      r.byte_class = nsc_pkg::CLASS_CHECKSUM;
      star_run++;
    end else begin
      r.byte_class = nsc_pkg::CLASS_TRAILER;
    end

    if (c == nsc_pkg::CHAR_COMMA && n_commas < 15) n_commas++;

    // a character is checked once two more have arrived
    if (delay_fill == 2) begin
      chk = delay_chars[0];
      if (hdr_pos < HLEN) begin
        want = hdr_word[8*(HLEN-1-hdr_pos) +: 8];
        if (chk != want) hdr_match = 1'b0;
        hdr_pos++;
      end
      if (scan_ph == PH_AFTER) begin
        if (tail_cnt < 4) tail_chars[tail_cnt] = chk;
        if (tail_cnt < 7) tail_cnt++;
      end
      if (chk == nsc_pkg::CHAR_STAR) scan_ph = PH_AFTER;
      if (scan_ph == PH_INSIDE) xsum ^= chk;
      if (chk == nsc_pkg::CHAR_DOLLAR) scan_ph = PH_INSIDE;
    end
    delay_chars[0] = delay_chars[1];
    delay_chars[1] = c;
    if (delay_fill < 2) delay_fill++;

    // verdict on the last character
    if (last) begin
      hok = hdr_match && (hdr_pos >= HLEN);
      cok = (tail_cnt == 2) && (tail_chars[0] == hex_char(xsum[7:4])) &&
            (tail_chars[1] == hex_char(xsum[3:0]));
      r.frame_done  = 1'b1;
      r.header_ok   = hok;
      r.checksum_ok = cok;
      r.frame_valid = hok && cok;
      clear_frame();
    end
  endtask

  task automatic add_row(input logic [7:0] c, input logic last, input bit typed,
                         input nsc_pkg::result_t e);
    dir_data.push_back(c);
    dir_last.push_back(last);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
  endtask

  // one input transfer after a random gap
  task automatic send_char(input logic [7:0] c, input logic last, input bit typed,
                           input nsc_pkg::result_t e);
    int unsigned      gap;
    nsc_pkg::result_t r;
    gap = tx_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_result(c, last, r);
    pending_results.push_back(typed ? e : r);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // random sentence, mostly well formed, sometimes noise or broken
  task automatic build_frame();
    logic [7:0]  ck;
    logic [7:0]  c;
    logic [7:0]  hi;
    logic [7:0]  lo;
    int unsigned nf;
    int unsigned mode;
    bit          own_hdr;
    frame_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ck = 8'h00;
    own_hdr = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < HLEN; i++) begin
      if (own_hdr) c = hdr_word[8*(HLEN-1-i) +: 8];
      else c = (i == 0) ? nsc_pkg::CHAR_DOLLAR : rand_text();
      frame_q.push_back(c);
      if (i > 0) ck ^= c;
    end
    nf = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 6);
    repeat (nf) begin
      frame_q.push_back(nsc_pkg::CHAR_COMMA);
      ck ^= nsc_pkg::CHAR_COMMA;
      repeat ($urandom_range(0, 4)) begin
        c = rand_text();
        frame_q.push_back(c);
        ck ^= c;
      end
    end
    mode = $urandom_range(0, 9);
    if (mode == 6) ck ^= 8'($urandom_range(1, 255));
    hi = hex_char(ck[7:4]);
    lo = hex_char(ck[3:0]);
    if (mode == 7) begin
      if (hi > 8'h39) hi += 8'h20;
      if (lo > 8'h39) lo += 8'h20;
    end
    case (mode)
      8: begin
        frame_q.push_back(nsc_pkg::CHAR_STAR);
        frame_q.push_back(hi);
        if ($urandom_range(0, 1) == 1) begin
          frame_q.push_back(lo);
          frame_q.push_back(rand_text());
        end
      end
      9: begin
        case ($urandom_range(0, 2))
          0: ;
          1: begin
            // dollar right after the star reopens the summed part without clearing the sum
            frame_q.push_back(nsc_pkg::CHAR_STAR);
            frame_q.push_back(nsc_pkg::CHAR_DOLLAR);
            frame_q.push_back(8'h30);
            frame_q.push_back(8'h30);
          end
          default: begin
            frame_q.push_back(nsc_pkg::CHAR_STAR);
            frame_q.push_back(8'($urandom_range(0, 255)));
            frame_q.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
      default: begin
        frame_q.push_back(nsc_pkg::CHAR_STAR);
        frame_q.push_back(hi);
        frame_q.push_back(lo);
      end
    endcase
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        frame_q.push_back(8'h0D);
        frame_q.push_back(8'h0A);
        frame_q.push_back(rand_text());
      end
      default: begin
        frame_q.push_back(8'h0D);
        frame_q.push_back(8'h0A);
      end
    endcase
  endtask

  function automatic void note_field(input string nm, input logic [7:0] e,
                                     input logic [7:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", nm, e, a);
    end
  endfunction

  // result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int unsigned      stall;
    nsc_pkg::result_t e;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tdata %h tuser %h tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        e = pending_results.pop_front();
        note_field("echo_byte",   e.echo_byte,          m_axis_tdata[7:0]);
        note_field("field_index", {4'h0, e.field_index}, {4'h0, m_axis_tdata[11:8]});
        note_field("byte_class",  {6'h0, e.byte_class},  {6'h0, m_axis_tuser});
        note_field("frame_done",  {7'h0, e.frame_done},  {7'h0, m_axis_tlast});
        note_field("header_ok",   {7'h0, e.header_ok},   {7'h0, m_axis_tdata[12]});
        note_field("checksum_ok", {7'h0, e.checksum_ok}, {7'h0, m_axis_tdata[13]});
        note_field("frame_valid", {7'h0, e.frame_valid}, {7'h0, m_axis_tdata[14]});
      end
    end
  end

  // stimulus
  initial begin
    int unsigned       sent;
    logic [8*HLEN-1:0] hdr_val;
    hdr_word = nsc_pkg::HEADER_RESET[8*HLEN-1:0];
    clear_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // valid sentence with the reset header, checksum 5F
    add_row(nsc_pkg::CHAR_DOLLAR, 1'b0, 1'b1,
            nsc_pkg::result_t'({nsc_pkg::CHAR_DOLLAR, 4'd0, nsc_pkg::CLASS_DATA,
                                1'b0, 1'b0, 1'b0, 1'b0}));
    add_text("GTIMU,1*5F");
    add_row(8'h0D, 1'b0, 1'b0, '0);
    add_row(8'h0A, 1'b1, 1'b1,
            nsc_pkg::result_t'({8'h0A, 4'd1, nsc_pkg::CLASS_TRAILER,
                                1'b1, 1'b1, 1'b1, 1'b1}));
    // one-character frames at both byte extremes: too short for a header
    add_row(8'hFF, 1'b1, 1'b1,
            nsc_pkg::result_t'({8'hFF, 4'd0, nsc_pkg::CLASS_DATA,
                                1'b1, 1'b0, 1'b0, 1'b0}));
    add_row(8'h00, 1'b1, 1'b1,
            nsc_pkg::result_t'({8'h00, 4'd0, nsc_pkg::CLASS_DATA,
                                1'b1, 1'b0, 1'b0, 1'b0}));
    // empty body, checksum with leading zero, short header
    add_text("$*00");
    add_row(8'h0D, 1'b0, 1'b0, '0);
    add_row(8'h0A, 1'b1, 1'b1,
            nsc_pkg::result_t'({8'h0A, 4'd0, nsc_pkg::CLASS_TRAILER,
                                1'b1, 1'b0, 1'b1, 1'b0}));

    foreach (dir_data[i]) send_char(dir_data[i], dir_last[i], dir_typed[i], dir_exp[i]);
    drain();

    // random phases, one header setting each
    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        case (p)
          1: hdr_val = '0;
          2: hdr_val = '1;
          3: begin
            hdr_val[8*HLEN-1 -: 8] = nsc_pkg::CHAR_DOLLAR;
            for (int i = 1; i < HLEN; i++) hdr_val[8*(HLEN-1-i) +: 8] = rand_text();
          end
          4: hdr_val = 48'h2447_5047_4741;
          default: hdr_val = nsc_pkg::HEADER_RESET[8*HLEN-1:0];
        endcase
        // header register transfer while idle
        cfg_valid_i <= 1'b1;
        cfg_data_i  <= hdr_val;
        do @(posedge clk_i); while (!cfg_ready_o);
        cfg_valid_i <= 1'b0;
        hdr_word = hdr_val;
        @(posedge clk_i);
      end
      sent = 0;
      while (sent < 310) begin
        build_frame();
        tx_burst = ($urandom_range(0, 3) == 0);
        foreach (frame_q[i])
          send_char(frame_q[i], (i == frame_q.size() - 1), 1'b0, '0);
        sent += frame_q.size();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("** nmea_sentence_checker: PASSED **");
    end else begin
      $display("** nmea_sentence_checker: FAILED **");
    end
    $finish;
  end

endmodule
